// ===== src/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted insert position search package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int DATA_W        = 32;
  localparam int POS_W         = 11;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic do_clear;
    logic do_append;
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

endpackage

// ===== src/sis_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted insert position search controller
// Sequences request acceptance, search probes and loading of the result.
// ----------------------------------------------------------------------------
module sis_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       operation,
  output logic             out_valid,
  input  logic             out_stall,
  input  sis_pkg::status_t sts,
  output sis_pkg::cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (operation)
            sis_pkg::OP_CLEAR:  cmd.do_clear  = 1'b1;
            sis_pkg::OP_APPEND: cmd.do_append = 1'b1;
            sis_pkg::OP_QUERY:  cmd.start     = 1'b1;
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (!sts.done) begin
          cmd.step = 1'b1;
        end else if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.start) state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (cmd.load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/sis_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted insert position search datapath
// Element memory, element count, search bounds, probe compare and result.
// ----------------------------------------------------------------------------
module sis_datapath #(
  parameter int DEPTH = sis_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sis_pkg::cmd_t                      cmd,
  output sis_pkg::status_t                   sts,
  input  logic signed [sis_pkg::DATA_W-1:0]  value,
  output logic        [sis_pkg::POS_W-1:0]   position,
  output logic                               found
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic signed [sis_pkg::DATA_W-1:0] mem [DEPTH];

  logic [CW-1:0]                     count;
  logic signed [sis_pkg::DATA_W-1:0] key;
  logic signed [sis_pkg::DATA_W-1:0] rdata;
  logic [CW-1:0]                     lo;
  logic [CW-1:0]                     hx;
  logic [AW-1:0]                     mid_q;
  logic                              first;

  logic [CW-1:0] cur_lo;
  logic [CW-1:0] cur_hx;
  logic          hit;
  logic [SW-1:0] sum;
  logic [SW-1:0] mid_wide;
  logic [AW-1:0] mid;

  // The bounds are kept as [lo, hx) so that an empty range needs no sign bit.
  always_comb begin
    cur_lo = lo;
    cur_hx = hx;
    hit    = 1'b0;
    if (!first) begin
      if (rdata == key) begin
        hit = 1'b1;
      end else if (rdata < key) begin
        cur_lo = CW'(mid_q) + CW'(1);
      end else begin
        cur_hx = CW'(mid_q);
      end
    end
  end

  assign sum      = SW'(cur_lo) + SW'(cur_hx) - SW'(1);
  assign mid_wide = sum >> 1;
  assign mid      = mid_wide[AW-1:0];
  assign sts.done = hit || !(cur_lo < cur_hx);

  always_ff @(posedge clk) begin
    if (cmd.do_append && (count < CW'(DEPTH))) begin
      mem[count[AW-1:0]] <= value;
    end
    if (cmd.step) begin
      rdata <= mem[mid];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_clear) begin
      count <= '0;
    end else if (cmd.do_append && (count < CW'(DEPTH))) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key   <= value;
      lo    <= '0;
      hx    <= count;
      first <= 1'b1;
    end else if (cmd.step) begin
      lo    <= cur_lo;
      hx    <= cur_hx;
      mid_q <= mid;
      first <= 1'b0;
    end
    if (cmd.load_out) begin
      position <= hit ? sis_pkg::POS_W'(mid_q) : sis_pkg::POS_W'(cur_lo);
      found    <= hit;
    end
  end

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && hit) |-> (CW'(mid_q) < count))
    else $error("matching probe lies beyond the element count");

  a_insert_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && !hit) |-> (cur_lo <= count))
    else $error("insertion position lies beyond the element count");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> ((cur_lo < cur_hx) && (cur_hx <= count)))
    else $error("probe issued outside a nonempty range");

endmodule

// ===== src/sorted_insert_position_search.sv =====
// ----------------------------------------------------------------------------
// Sorted insert position search
// Binary search for the insertion point in an ascending store of elements.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid, in_stall, operation, value).
// A clear request empties the store and an append request writes value at the
// end of the store; both produce no result. Appends beyond
// DEPTH elements are dropped. A query request searches for value and gives one
// result on the output channel (out_valid, out_stall, position, found).
// A query probes one element per cycle from the element memory, whose read
// port is the loop, and halves the search range with each probe.
// One query is in flight at a time; in_stall is high while it searches, and
// the next request is taken as soon as its result sits in the output register.
// When the receiver stalls, the result holds in the output register; a finished
// search waits for that register to free before it completes.
// Reset empties the store and drops any pending result. No clearing pass is
// needed, since only entries below the element count are ever read.
// ----------------------------------------------------------------------------
module sorted_insert_position_search #(
  parameter int DEPTH = sis_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        operation,
  input  logic signed [sis_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sis_pkg::POS_W-1:0]         position,
  output logic                              found
);

  sis_pkg::cmd_t    cmd;
  sis_pkg::status_t sts;

  sis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sis_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .value    (value),
    .position (position),
    .found    (found)
  );

endmodule
